// File: rtl/sfpd_pkg.sv
// sfpd_pkg: shared types and constants for the sync framed packet deframer
// holds phase enum, result kinds, config indexes, reset values and the result struct
// no dependencies
`timescale 1ns / 1ps

package sfpd_pkg;

    // default counter width
    localparam int COUNTER_BITS_DEF = 16;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_MAX_LEN     = 2'd2;

    // configuration reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
    localparam logic [15:0] MAX_LEN_RST     = 16'd8192;

    // result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_GOOD   = 2'd1;
    localparam logic [1:0] KIND_CKERR  = 2'd2;
    localparam logic [1:0] KIND_LENREJ = 2'd3;

    // header byte positions
    localparam logic [1:0] HDR_CLASS  = 2'd0;
    localparam logic [1:0] HDR_ID     = 2'd1;
    localparam logic [1:0] HDR_LEN_LO = 2'd2;
    localparam logic [1:0] HDR_LEN_HI = 2'd3;

    // frame parser phases
    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_HEADER,
        PH_PAYLOAD,
        PH_CKA,
        PH_CKB
    } phase_t;

    // one result transaction as produced by the parser
    typedef struct packed {
        logic        fire;
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [7:0]  msg_class;
        logic [7:0]  msg_id;
        logic [15:0] payload_len;
        logic [15:0] good_frames;
        logic [15:0] checksum_errors;
        logic [15:0] resyncs;
        logic        last;
    } result_t;

endpackage

// File: rtl/sfpd_parser.sv
// sfpd_parser: frame state machine, 8-bit fletcher-style sums (modulo 256) and frame counters
// advances one byte per step and reports the result of that byte combinationally
// depends on sfpd_pkg
`timescale 1ns / 1ps

module sfpd_parser #(
    parameter int COUNTER_BITS = sfpd_pkg::COUNTER_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        sync_first,
    input  logic [7:0]        sync_second,
    input  logic [15:0]       max_len,
    output sfpd_pkg::result_t res
);

    import sfpd_pkg::*;

    localparam int ExtW = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;

    phase_t                  phase_reg, phase_next;
    logic [7:0]              class_reg, class_next;
    logic [7:0]              id_reg, id_next;
    logic [15:0]             len_reg, len_next;
    logic [1:0]              hdr_idx_reg, hdr_idx_next;
    logic [15:0]             byte_count_reg, byte_count_next;
    logic [7:0]              sum_a_reg, sum_a_next;
    logic [7:0]              sum_b_reg, sum_b_next;
    logic [7:0]              check_a_reg, check_a_next;
    logic                    skipping_reg, skipping_next;
    logic [COUNTER_BITS-1:0] good_reg, good_next;
    logic [COUNTER_BITS-1:0] error_reg, error_next;
    logic [COUNTER_BITS-1:0] resync_reg, resync_next;

    logic [7:0]  sum_a_add;
    logic [7:0]  sum_b_add;
    logic [15:0] len_full;
    logic [15:0] count_inc;
    logic        check_ok;
    logic [ExtW-1:0] good_ext, error_ext, resync_ext;

    // running fletcher sums and header helpers
    assign sum_a_add = sum_a_reg + rx_byte;
    assign sum_b_add = sum_b_reg + sum_a_add;
    assign len_full  = {rx_byte, len_reg[7:0]};
    assign count_inc = byte_count_reg + 16'd1;
    assign check_ok  = (check_a_reg == sum_a_reg) && (rx_byte == sum_b_reg);

    // next state
    always_comb
    begin
        phase_next      = phase_reg;
        class_next      = class_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        hdr_idx_next    = hdr_idx_reg;
        byte_count_next = byte_count_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        check_a_next    = check_a_reg;
        skipping_next   = skipping_reg;
        good_next       = good_reg;
        error_next      = error_reg;
        resync_next     = resync_reg;
        unique case (phase_reg)
            PH_HUNT1:
            begin
                if (rx_byte == sync_first)
                begin
                    phase_next = PH_HUNT2;
                end
                else
                begin
                    skipping_next = 1'b1;
                end
            end
            PH_HUNT2:
            begin
                if (rx_byte == sync_second)
                begin
                    if (skipping_reg)
                    begin
                        resync_next = resync_reg + COUNTER_BITS'(1);
                    end
                    skipping_next   = 1'b0;
                    phase_next      = PH_HEADER;
                    hdr_idx_next    = HDR_CLASS;
                    byte_count_next = '0;
                    sum_a_next      = '0;
                    sum_b_next      = '0;
                end
                else
                begin
                    skipping_next = 1'b1;
                    if (rx_byte != sync_first)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
            end
            PH_HEADER:
            begin
                sum_a_next   = sum_a_add;
                sum_b_next   = sum_b_add;
                hdr_idx_next = hdr_idx_reg + 2'd1;
                unique case (hdr_idx_reg)
                    HDR_CLASS:  class_next = rx_byte;
                    HDR_ID:     id_next = rx_byte;
                    HDR_LEN_LO: len_next = {8'd0, rx_byte};
                    HDR_LEN_HI:
                    begin
                        len_next        = len_full;
                        byte_count_next = '0;
                        if (len_full > max_len)
                        begin
                            resync_next = resync_reg + COUNTER_BITS'(1);
                            phase_next  = PH_HUNT1;
                        end
                        else if (len_full == 16'd0)
                        begin
                            phase_next = PH_CKA;
                        end
                        else
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    default: ;
                endcase
            end
            PH_PAYLOAD:
            begin
                sum_a_next      = sum_a_add;
                sum_b_next      = sum_b_add;
                byte_count_next = count_inc;
                if (count_inc >= len_reg)
                begin
                    phase_next = PH_CKA;
                end
            end
            PH_CKA:
            begin
                check_a_next = rx_byte;
                phase_next   = PH_CKB;
            end
            PH_CKB:
            begin
                phase_next = PH_HUNT1;
                if (check_ok)
                begin
                    good_next = good_reg + COUNTER_BITS'(1);
                end
                else
                begin
                    error_next = error_reg + COUNTER_BITS'(1);
                end
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase
    end

    // counter views on 16 bits
    assign good_ext   = ExtW'(good_next);
    assign error_ext  = ExtW'(error_next);
    assign resync_ext = ExtW'(resync_next);

    // result of this byte
    always_comb
    begin
        res.fire            = 1'b0;
        res.kind            = KIND_DATA;
        res.data_byte       = 8'd0;
        res.last            = 1'b0;
        res.msg_class       = class_next;
        res.msg_id          = id_next;
        res.payload_len     = len_next;
        res.good_frames     = good_ext[15:0];
        res.checksum_errors = error_ext[15:0];
        res.resyncs         = resync_ext[15:0];
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (hdr_idx_reg == HDR_LEN_HI && len_full > max_len)
                begin
                    res.fire = 1'b1;
                    res.kind = KIND_LENREJ;
                    res.last = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                res.fire      = 1'b1;
                res.kind      = KIND_DATA;
                res.data_byte = rx_byte;
            end
            PH_CKB:
            begin
                res.fire = 1'b1;
                res.kind = check_ok ? KIND_GOOD : KIND_CKERR;
                res.last = 1'b1;
            end
            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT1;
            class_reg      <= '0;
            id_reg         <= '0;
            len_reg        <= '0;
            hdr_idx_reg    <= HDR_CLASS;
            byte_count_reg <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            check_a_reg    <= '0;
            skipping_reg   <= 1'b0;
            good_reg       <= '0;
            error_reg      <= '0;
            resync_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            class_reg      <= class_next;
            id_reg         <= id_next;
            len_reg        <= len_next;
            hdr_idx_reg    <= hdr_idx_next;
            byte_count_reg <= byte_count_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            check_a_reg    <= check_a_next;
            skipping_reg   <= skipping_next;
            good_reg       <= good_next;
            error_reg      <= error_next;
            resync_reg     <= resync_next;
        end
    end

endmodule

// File: rtl/sync_framed_packet_deframer_core.sv
// sync_framed_packet_deframer_core: top level with input register, config and result register
// depends on sfpd_pkg and sfpd_parser
// path: a byte accepted into the input register is parsed from there, and its result, if it
//   has one, is captured in the result register when that register is free or is read
// throughput: one byte per cycle; a result held while out_ready is low stalls the input
// reset: asynchronous active low; clears pipeline valids, parser state, counters and
//   loads the default sync bytes and length limit
`timescale 1ns / 1ps

module sync_framed_packet_deframer_core #(
    parameter int COUNTER_BITS = sfpd_pkg::COUNTER_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    // results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  data_byte,
    output logic [7:0]  msg_class,
    output logic [7:0]  msg_id,
    output logic [15:0] payload_len,
    output logic [15:0] good_frames,
    output logic [15:0] checksum_errors,
    output logic [15:0] resyncs,
    output logic        last
);

    import sfpd_pkg::*;

    logic [7:0]  sync_first_reg;
    logic [7:0]  sync_second_reg;
    logic [15:0] max_len_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    result_t     res;
    logic        advance;

    // pipeline flow control
    assign advance        = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready       = !in_valid_reg || advance;
    assign out_valid_next = (out_valid_reg && !out_ready) || (advance && res.fire);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_len_reg     <= MAX_LEN_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata[7:0];
                CFG_SYNC_SECOND: sync_second_reg <= cfg_wdata[7:0];
                CFG_MAX_LEN:     max_len_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // frame parser
    sfpd_parser #(
        .COUNTER_BITS(COUNTER_BITS)
    ) u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .rx_byte     (in_byte_reg),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .max_len     (max_len_reg),
        .res         (res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.fire)
        begin
            out_reg <= res;
        end
    end

    // result transaction ports
    assign out_valid       = out_valid_reg;
    assign kind            = out_reg.kind;
    assign data_byte       = out_reg.data_byte;
    assign msg_class       = out_reg.msg_class;
    assign msg_id          = out_reg.msg_id;
    assign payload_len     = out_reg.payload_len;
    assign good_frames     = out_reg.good_frames;
    assign checksum_errors = out_reg.checksum_errors;
    assign resyncs         = out_reg.resyncs;
    assign last            = out_reg.last;

endmodule
